/* src/ddwe_pkg.sv */
// ddwe_pkg: shared widths, register map, reset values and sequencer states
// for the dust density window averager; depends on nothing else
package ddwe_pkg;

   // field widths, fixed by the item format
   localparam int CODE_W     = 12;
   localparam int DENS_W     = 14;
   localparam int GAIN_W     = 16;
   localparam int ALPHA_W    = 16;
   localparam int WLEN_W     = 5;
   localparam int SMOOTH_W   = 30;
   localparam int STEP_W     = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // index of the last serial step of each phase
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(CODE_W - 1);
   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CODE_W - 1);
   localparam logic [STEP_W-1:0] EMA_LAST = STEP_W'(ALPHA_W - 1);

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_GAIN   = 2'd1;
   localparam logic [1:0] REG_ALPHA  = 2'd2;
   localparam logic [1:0] REG_WLEN   = 2'd3;

   // register reset values
   localparam logic [CODE_W-1:0]  OFFSET_RESET = 12'd372;
   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd8980;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd6554;
   localparam logic [WLEN_W-1:0]  WLEN_RESET   = 5'd10;

   localparam logic [DENS_W-1:0]  DENS_MAX     = 14'h3FFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_EMA,
      ST_LOAD
   } ddwe_state_type;

endpackage

/* src/ddwe_if.sv */
// ddwe_if: valid/ready channel interfaces for sample beats and result beats
// depends on ddwe_pkg for the field widths
interface ddwe_req_if;
   logic                         valid;
   logic                         ready;
   logic [ddwe_pkg::CODE_W-1:0]  adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface ddwe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ddwe_pkg::CODE_W-1:0]  average_code;
   logic [ddwe_pkg::DENS_W-1:0]  instant_density;
   logic [ddwe_pkg::DENS_W-1:0]  smoothed_density;

   modport source (output valid, output average_code, output instant_density,
                   output smoothed_density, input ready);
   modport sink (input valid, input average_code, input instant_density,
                 input smoothed_density, output ready);
endinterface

/* src/dust_density_window_ema.sv */
// dust_density_window_ema: window average, offset, scale and moving average
// depends on ddwe_pkg and the channel interfaces in ddwe_if.sv
//
// usage
//   req_bus carries one adc sample per beat; rsp_bus one result beat (average
//   code, instant density, smoothed density) per completed window. the user
//   must write registers over the apb-style port only while idle (not enforced).
// sequencing
//   a sample that does not close the window is summed and req_bus.ready stays
//   high. a sample that closes the window starts a serial sequencer:
//   restoring division (one quotient bit a cycle), shift-add scaling by the
//   gain (one bit of the difference a cycle), the moving average update (a
//   latch step, then one bit of alpha a cycle) and a load step that writes
//   the result beat once the output register is free. after a closing sample
//   is accepted, req_bus.ready stays low until the sequencer is back in idle,
//   so no further sample is taken while a window is worked on.
// reset
//   synchronous reset restores register defaults, clears the window sum,
//   the sample count, the smoothed accumulator and any pending result.
// stalls
//   a finished result waits in the output register; new samples are taken
//   meanwhile, and a further completed window waits in the load state until
//   the pending beat has been taken.
module dust_density_window_ema #(
   parameter int ADC_BITS   = 12,
   parameter int MAX_WINDOW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ddwe_req_if.sink                            req_bus,
   ddwe_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ddwe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ddwe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ddwe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int CODE_W   = ddwe_pkg::CODE_W;
   localparam int DENS_W   = ddwe_pkg::DENS_W;
   localparam int GAIN_W   = ddwe_pkg::GAIN_W;
   localparam int ALPHA_W  = ddwe_pkg::ALPHA_W;
   localparam int WLEN_W   = ddwe_pkg::WLEN_W;
   localparam int SMOOTH_W = ddwe_pkg::SMOOTH_W;
   localparam int STEP_W   = ddwe_pkg::STEP_W;
   localparam int DATA_W   = ddwe_pkg::CSR_DATA_W;

   // sample count and divisor hold up to MAX_WINDOW; the sum needs IDX_W more bits
   localparam int IDX_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = CODE_W + IDX_W;
   localparam int CMP_W = (IDX_W > WLEN_W) ? IDX_W : WLEN_W;
   // ema terms: difference and partial products in 31-bit two's complement
   localparam int EMA_W = SMOOTH_W + 1;

   localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((64'd1 << ADC_BITS) - 64'd1);

   // configuration registers
   logic [CODE_W-1:0]   offset_ff, offset_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [WLEN_W-1:0]   wlen_ff, wlen_in;

   // window state
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic [SMOOTH_W-1:0] smooth_ff, smooth_in;

   // sequencer
   ddwe_pkg::ddwe_state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // divider: dividend bits shift out of the top, quotient bits in at the bottom
   logic [CODE_W-1:0]   divq_ff, divq_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [IDX_W-1:0]    divisor_ff, divisor_in;

   // gain scaler
   logic [CODE_W-1:0]   diff_ff, diff_in;
   logic [GAIN_W-1:0]   prod_ff, prod_in;

   // moving average
   logic [DENS_W-1:0]   inst_ff, inst_in;
   logic [ALPHA_W-1:0]  alpha_sh_ff, alpha_sh_in;
   logic [EMA_W-1:0]    delta_ff, delta_in;
   logic [EMA_W-1:0]    ema_ff, ema_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [DENS_W-1:0]   rsp_inst_ff, rsp_inst_in;
   logic [DENS_W-1:0]   rsp_smooth_ff, rsp_smooth_in;

   // combinational helpers
   logic                req_beat;
   logic                csr_write;
   logic [CODE_W-1:0]   sample;
   logic [SUM_W-1:0]    sum_next;
   logic [IDX_W-1:0]    taken;
   logic [IDX_W-1:0]    eff_window;
   logic [CMP_W-1:0]    wlen_ext;
   logic [IDX_W:0]      trial;
   logic                qbit;
   logic [CODE_W-1:0]   avg_next;
   logic [GAIN_W:0]     prod_sum;
   logic [DENS_W-1:0]   inst_sat;
   logic [EMA_W:0]      ema_sum;
   logic [EMA_W-1:0]    smooth_sum;
   logic                out_free;

   assign pready       = 1'b1;
   assign req_beat     = req_bus.valid && req_bus.ready;
   assign csr_write    = psel && penable && pwrite;
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready            = (state_ff == ddwe_pkg::ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.average_code     = rsp_avg_ff;
   assign rsp_bus.instant_density  = rsp_inst_ff;
   assign rsp_bus.smoothed_density = rsp_smooth_ff;

   // register read-back
   always_comb begin
      unique case (paddr[3:2])
         ddwe_pkg::REG_OFFSET: prdata = DATA_W'(offset_ff);
         ddwe_pkg::REG_GAIN:   prdata = DATA_W'(gain_ff);
         ddwe_pkg::REG_ALPHA:  prdata = DATA_W'(alpha_ff);
         ddwe_pkg::REG_WLEN:   prdata = DATA_W'(wlen_ff);
         default:              prdata = '0;
      endcase
   end

   // effective window: zero counts as one, long windows clamp to MAX_WINDOW
   always_comb begin
      wlen_ext = CMP_W'(wlen_ff);
      if (wlen_ff == '0) begin
         eff_window = IDX_W'(1);
      end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
         eff_window = IDX_W'(MAX_WINDOW);
      end else begin
         eff_window = IDX_W'(wlen_ext);
      end
   end

   // datapath arithmetic, one narrow step per cycle
   always_comb begin
      sample   = req_bus.adc_sample & ADC_MASK;
      sum_next = sum_ff + SUM_W'(sample);
      taken    = index_ff + IDX_W'(1);

      // restoring division step
      trial    = {rem_ff, divq_ff[CODE_W-1]};
      qbit     = (trial >= {1'b0, divisor_ff});
      avg_next = {divq_ff[CODE_W-2:0], qbit};

      // lsb-first shift-add: dropping the low bit each step floors the product
      prod_sum = {1'b0, prod_ff} + (diff_ff[0] ? {1'b0, gain_ff} : '0);
      inst_sat = (prod_ff[GAIN_W-1:DENS_W] != '0) ? ddwe_pkg::DENS_MAX
                                                 : prod_ff[DENS_W-1:0];

      // signed lsb-first multiply of the difference by alpha
      ema_sum  = {ema_ff[EMA_W-1], ema_ff}
               + (alpha_sh_ff[0] ? {delta_ff[EMA_W-1], delta_ff} : '0);
      smooth_sum = {1'b0, smooth_ff} + ema_ff;
   end

   // sequencer and next-state logic
   always_comb begin
      offset_in     = offset_ff;
      gain_in       = gain_ff;
      alpha_in      = alpha_ff;
      wlen_in       = wlen_ff;
      sum_in        = sum_ff;
      index_in      = index_ff;
      smooth_in     = smooth_ff;
      state_in      = state_ff;
      step_in       = step_ff;
      divq_in       = divq_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      inst_in       = inst_ff;
      alpha_sh_in   = alpha_sh_ff;
      delta_in      = delta_ff;
      ema_in        = ema_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_inst_in   = rsp_inst_ff;
      rsp_smooth_in = rsp_smooth_ff;

      // pending beat leaves when taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (paddr[3:2])
            ddwe_pkg::REG_OFFSET: offset_in = pwdata[CODE_W-1:0];
            ddwe_pkg::REG_GAIN:   gain_in   = pwdata[GAIN_W-1:0];
            ddwe_pkg::REG_ALPHA:  alpha_in  = pwdata[ALPHA_W-1:0];
            ddwe_pkg::REG_WLEN:   wlen_in   = pwdata[WLEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ddwe_pkg::ST_IDLE: begin
            if (req_beat) begin
               if (taken < eff_window) begin
                  sum_in   = sum_next;
                  index_in = taken;
               end else begin
                  // window closes: quotient fits the code width, so the top
                  // bits of the sum already form the starting remainder
                  divq_in    = sum_next[CODE_W-1:0];
                  rem_in     = sum_next[SUM_W-1:CODE_W];
                  divisor_in = taken;
                  sum_in     = '0;
                  index_in   = '0;
                  step_in    = '0;
                  state_in   = ddwe_pkg::ST_DIV;
               end
            end
         end
         ddwe_pkg::ST_DIV: begin
            divq_in = avg_next;
            rem_in  = qbit ? IDX_W'(trial - {1'b0, divisor_ff}) : trial[IDX_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ddwe_pkg::DIV_LAST) begin
               // clamp at zero below the clean-air offset
               diff_in  = (avg_next > offset_ff) ? (avg_next - offset_ff) : '0;
               prod_in  = '0;
               step_in  = '0;
               state_in = ddwe_pkg::ST_MUL;
            end
         end
         ddwe_pkg::ST_MUL: begin
            prod_in = prod_sum[GAIN_W:1];
            diff_in = diff_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ddwe_pkg::MUL_LAST) begin
               step_in  = '0;
               state_in = ddwe_pkg::ST_EMA;
            end
         end
         ddwe_pkg::ST_EMA: begin
            if (step_ff == '0) begin
               // first ema cycle: latch the saturated density and new - old
               inst_in     = inst_sat;
               delta_in    = {1'b0, inst_sat, {(EMA_W - 1 - DENS_W){1'b0}}}
                           - {1'b0, smooth_ff};
               alpha_sh_in = alpha_ff;
               ema_in      = '0;
               step_in     = STEP_W'(1);
            end else begin
               ema_in      = ema_sum[EMA_W:1];
               alpha_sh_in = alpha_sh_ff >> 1;
               step_in     = step_ff + STEP_W'(1);
               if (step_ff == ddwe_pkg::EMA_LAST + STEP_W'(1)) begin
                  step_in  = '0;
                  state_in = ddwe_pkg::ST_LOAD;
               end
            end
         end
         ddwe_pkg::ST_LOAD: begin
            if (out_free) begin
               smooth_in     = smooth_sum[SMOOTH_W-1:0];
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = divq_ff;
               rsp_inst_in   = inst_ff;
               rsp_smooth_in = smooth_sum[SMOOTH_W-1:SMOOTH_W-DENS_W];
               state_in      = ddwe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ddwe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= ddwe_pkg::OFFSET_RESET;
         gain_ff      <= ddwe_pkg::GAIN_RESET;
         alpha_ff     <= ddwe_pkg::ALPHA_RESET;
         wlen_ff      <= ddwe_pkg::WLEN_RESET;
         sum_ff       <= '0;
         index_ff     <= '0;
         smooth_ff    <= '0;
         state_ff     <= ddwe_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         gain_ff      <= gain_in;
         alpha_ff     <= alpha_in;
         wlen_ff      <= wlen_in;
         sum_ff       <= sum_in;
         index_ff     <= index_in;
         smooth_ff    <= smooth_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      divq_ff       <= divq_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      inst_ff       <= inst_in;
      alpha_sh_ff   <= alpha_sh_in;
      delta_ff      <= delta_in;
      ema_ff        <= ema_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_inst_ff   <= rsp_inst_in;
      rsp_smooth_ff <= rsp_smooth_in;
   end

endmodule

/* test/ddwe_result_checker.sv */
`timescale 1ns / 100ps
// ddwe_result_checker: watches the sample, result and register traffic of
// dust_density_window_ema, predicts every result beat and compares it
// depends on ddwe_pkg and the channel interfaces in ddwe_if.sv
module ddwe_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   ddwe_req_if                                 req_bus,
   ddwe_rsp_if                                 rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [ddwe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ddwe_pkg::CSR_DATA_W-1:0]     pwdata,
   output int                                  mismatch_count,
   output int                                  results_awaited
);

   localparam int          CODE_W     = ddwe_pkg::CODE_W;
   localparam int          DENS_W     = ddwe_pkg::DENS_W;
   localparam int          GAIN_W     = ddwe_pkg::GAIN_W;
   localparam int          ALPHA_W    = ddwe_pkg::ALPHA_W;
   localparam int          WLEN_W     = ddwe_pkg::WLEN_W;
   localparam int          WINDOW_CAP = 16;
   localparam logic [15:0] CODE_MAX   = 16'((1 << CODE_W) - 1);

   typedef struct packed {
      logic [CODE_W-1:0] average_code;
      logic [DENS_W-1:0] instant_density;
      logic [DENS_W-1:0] smoothed_density;
   } density_beat_type;

   density_beat_type   awaited_beats[$];
   int                 fault_tally = 0;

   // register copies, taken from the bus
   logic [CODE_W-1:0]  offset_code;
   logic [GAIN_W-1:0]  gain_q16;
   logic [ALPHA_W-1:0] alpha_q16;
   logic [WLEN_W-1:0]  window_len;

   // window and smoothing state
   logic [15:0]        window_sum;
   logic [4:0]         window_fill;
   logic [31:0]        smoothed_acc;

   function automatic int unsigned window_target(input logic [WLEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > WINDOW_CAP) return WINDOW_CAP;
      return len;
   endfunction

   task automatic absorb_sample(input logic [CODE_W-1:0] sample);
      int unsigned       taken;
      logic [15:0]       mean;
      logic [CODE_W-1:0] excess;
      logic [63:0]       scaled;
      logic [63:0]       blend;
      logic [31:0]       smooth_q4;
      density_beat_type  beat;
      window_sum = window_sum + 16'(sample);
      taken = window_fill + 1;
      if (taken < window_target(window_len)) begin
         window_fill = 5'(taken);
         return;
      end
      // window closed: divide by the readings actually taken
      mean = window_sum / 16'(taken);
      window_sum = '0;
      window_fill = '0;
      beat.average_code = (mean > CODE_MAX) ? CODE_MAX[CODE_W-1:0] : mean[CODE_W-1:0];
      excess = (mean > 16'(offset_code)) ? CODE_W'(mean - 16'(offset_code)) : '0;
      scaled = (64'(excess) * 64'(gain_q16)) >> 12;
      beat.instant_density = (scaled > 64'(ddwe_pkg::DENS_MAX)) ? ddwe_pkg::DENS_MAX
                                                                 : scaled[DENS_W-1:0];
      blend = 64'(smoothed_acc) * (64'd65536 - 64'(alpha_q16))
            + (64'(beat.instant_density) << 16) * 64'(alpha_q16);
      smoothed_acc = blend[47:16];
      smooth_q4 = smoothed_acc >> 16;
      beat.smoothed_density = (smooth_q4 > 32'(ddwe_pkg::DENS_MAX)) ? ddwe_pkg::DENS_MAX
                                                                     : smooth_q4[DENS_W-1:0];
      awaited_beats.push_back(beat);
   endtask

   task automatic compare_beat();
      density_beat_type want;
      if (awaited_beats.size() == 0) begin
         $error("result beat with no prediction waiting: average_code %0d",
                rsp_bus.average_code);
         fault_tally++;
         return;
      end
      want = awaited_beats.pop_front();
      if (rsp_bus.average_code !== want.average_code) begin
         $error("average_code: expected %0d, actual %0d",
                want.average_code, rsp_bus.average_code);
         fault_tally++;
      end
      if (rsp_bus.instant_density !== want.instant_density) begin
         $error("instant_density: expected %0d, actual %0d",
                want.instant_density, rsp_bus.instant_density);
         fault_tally++;
      end
      if (rsp_bus.smoothed_density !== want.smoothed_density) begin
         $error("smoothed_density: expected %0d, actual %0d",
                want.smoothed_density, rsp_bus.smoothed_density);
         fault_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         offset_code  = ddwe_pkg::OFFSET_RESET;
         gain_q16     = ddwe_pkg::GAIN_RESET;
         alpha_q16    = ddwe_pkg::ALPHA_RESET;
         window_len   = ddwe_pkg::WLEN_RESET;
         window_sum   = '0;
         window_fill  = '0;
         smoothed_acc = '0;
         awaited_beats.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ddwe_pkg::CSR_ADDR_W-1:2])
               ddwe_pkg::REG_OFFSET: offset_code = pwdata[CODE_W-1:0];
               ddwe_pkg::REG_GAIN:   gain_q16    = pwdata[GAIN_W-1:0];
               ddwe_pkg::REG_ALPHA:  alpha_q16   = pwdata[ALPHA_W-1:0];
               ddwe_pkg::REG_WLEN:   window_len  = pwdata[WLEN_W-1:0];
               default: ;
            endcase
         end
         // older result leaves before a new prediction joins
         if (rsp_bus.valid && rsp_bus.ready) compare_beat();
         if (req_bus.valid && req_bus.ready) absorb_sample(req_bus.adc_sample);
      end
      results_awaited <= awaited_beats.size();
      mismatch_count  <= fault_tally;
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: stimulus and verdict for dust_density_window_ema
// depends on ddwe_pkg, ddwe_if.sv, the block itself and ddwe_result_checker
module testbench;

   localparam int CODE_W        = ddwe_pkg::CODE_W;
   localparam int GAIN_W        = ddwe_pkg::GAIN_W;
   localparam int ALPHA_W       = ddwe_pkg::ALPHA_W;
   localparam int WLEN_W        = ddwe_pkg::WLEN_W;
   localparam int CSR_ADDR_W    = ddwe_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W    = ddwe_pkg::CSR_DATA_W;

   localparam int SAMPLE_TARGET = 800;
   localparam int RANDOM_PHASES = 8;
   // margin for the serial sequencer to finish before touching registers
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    mismatch_count;
   int                    results_awaited;
   int unsigned           cycle_count = 0;
   int                    burst_left  = 0;
   int                    stall_left  = 0;
   int                    stall_mode  = 0;
   // offset in force, so that samples can be aimed around it
   logic [CODE_W-1:0]     offset_now  = ddwe_pkg::OFFSET_RESET;

   ddwe_req_if req_bus ();
   ddwe_rsp_if rsp_bus ();

   dust_density_window_ema dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ddwe_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .results_awaited (results_awaited)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case a beat never arrives
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side back-pressure: segments of free flow, random flicker and
   // long stalls, each of random length, so stalls land on every phase
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(1, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= 1'b0;
      endcase
   end

   // one register write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == ddwe_pkg::REG_OFFSET) offset_now = value[CODE_W-1:0];
   endtask

   task automatic set_all(input logic [CODE_W-1:0] offset, input logic [GAIN_W-1:0] gain,
                          input logic [ALPHA_W-1:0] alpha, input logic [WLEN_W-1:0] wlen);
      write_reg(ddwe_pkg::REG_OFFSET, CSR_DATA_W'(offset));
      write_reg(ddwe_pkg::REG_GAIN, CSR_DATA_W'(gain));
      write_reg(ddwe_pkg::REG_ALPHA, CSR_DATA_W'(alpha));
      write_reg(ddwe_pkg::REG_WLEN, CSR_DATA_W'(wlen));
   endtask

   // sample beats come in bursts; a gap opens only between bursts, and
   // valid stays high across consecutive beats of a burst
   task automatic push_sample(input logic [CODE_W-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid      <= 1'b1;
      req_bus.adc_sample <= sample;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // stop sending, let every predicted beat arrive, then cover the
   // sequencer latency in case a window is still being worked on
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // extremes, codes around the offset and plain random codes
   function automatic logic [CODE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return offset_now + CODE_W'($urandom_range(0, 64)) - CODE_W'(32);
         default: return CODE_W'($urandom);
      endcase
   endfunction

   // random register setting per phase, extremes included; window length
   // covers zero and values past the cap, but mostly stays short
   task automatic randomise_registers();
      logic [CODE_W-1:0]  offset;
      logic [GAIN_W-1:0]  gain;
      logic [ALPHA_W-1:0] alpha;
      logic [WLEN_W-1:0]  wlen;
      case ($urandom_range(0, 3))
         0:       offset = '0;
         1:       offset = '1;
         2:       offset = CODE_W'($urandom_range(200, 900));
         default: offset = CODE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       gain = '0;
         1:       gain = '1;
         default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       alpha = '0;
         1:       alpha = '1;
         default: alpha = ALPHA_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       wlen = WLEN_W'($urandom_range(0, 31));
         1:       wlen = WLEN_W'($urandom_range(1, 3));
         default: wlen = WLEN_W'($urandom_range(1, 16));
      endcase
      set_all(offset, gain, alpha, wlen);
   endtask

   initial begin
      logic [CODE_W-1:0] opening_mix [10];
      opening_mix        = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1,
                             12'd2048, 12'd4095, 12'd4095, 12'd372, 12'd373};
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.adc_sample <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, window of ten: one result from a mix of extremes
      foreach (opening_mix[i]) push_sample(opening_mix[i]);
      settle();

      // no offset, full gain and weight, single-sample window:
      // saturating density, then samples at and just above the offset
      set_all('0, '1, '1, WLEN_W'(1));
      push_sample('1);
      push_sample('0);
      push_sample(12'd1);
      settle();

      // offset at full scale, zero gain and weight, zero window length
      // which acts as a window of one; averages never exceed the offset
      set_all('1, '0, '0, '0);
      push_sample('1);
      push_sample(12'd2048);
      settle();

      // over-long window is capped; five readings in, the window is cut
      // to three, so the next reading closes it and divides by six
      set_all(ddwe_pkg::OFFSET_RESET, ddwe_pkg::GAIN_RESET, ddwe_pkg::ALPHA_RESET,
              WLEN_W'(31));
      repeat (5) push_sample(pick_sample());
      settle();
      write_reg(ddwe_pkg::REG_WLEN, CSR_DATA_W'(3));
      push_sample(pick_sample());
      settle();

      // random phases, each under its own register setting; a phase may end
      // mid-window, so the next setting often lands on a partial window
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         randomise_registers();
         repeat (SAMPLE_TARGET / RANDOM_PHASES) push_sample(pick_sample());
         settle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
